// ===== hdl/slf_pkg.sv =====
// Shared types and constants for the SLIP frame receiver.
// No dependencies; every other file refers to it by scoped names.
package slf_pkg;

  // SLIP framing codes
  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  // command field
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // result_kind field
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam int LEN_W = 12;
  // queue address field covers the largest supported store (4096 entries)
  localparam int ADDR_W_MAX = 12;
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 12'd20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [ADDR_W_MAX-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FRAME = 2'd2
  } op_t;

  // one request from the front to the back
  typedef struct packed {
    op_t        op;
    addr_t      addr;
    logic [7:0] data;
    len_t       length;
    logic       accepted;
    logic       in_range;
  } req_t;

endpackage

// ===== hdl/slf_front.sv =====
// Front end: takes input items, undoes SLIP escaping, tracks the write position
// and the min_frame_len register, and posts requests. Uses slf_pkg.
module slf_front #(
  parameter int FRAME_CAPACITY = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [7:0]          rx_byte,
  input  logic [10:0]         read_index,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [11:0]         cfg_data,
  output logic                push,
  output slf_pkg::req_t       push_req,
  input  logic                full
);

  localparam int PW = $clog2(FRAME_CAPACITY + 1);

  logic                escape_pending, escape_pending_next;
  logic [PW-1:0]       write_position, write_position_next;
  slf_pkg::len_t       min_frame_len;
  logic                accept;
  logic                do_store;
  logic [7:0]          byte_d;

  assign in_stall  = full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !full;

  always_comb begin
    escape_pending_next = escape_pending;
    write_position_next = write_position;
    push                = 1'b0;
    push_req            = '0;
    do_store            = 1'b0;
    byte_d              = rx_byte;
    if (accept) begin
      if (command == slf_pkg::CMD_READ) begin
        push              = 1'b1;
        push_req.op       = slf_pkg::OP_READ;
        push_req.addr     = slf_pkg::addr_t'({1'b0, read_index});
        push_req.in_range = ({21'b0, read_index} < 32'(FRAME_CAPACITY));
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        do_store            = 1'b1;
        if (rx_byte == slf_pkg::TFEND) begin
          byte_d = slf_pkg::FEND;
        end else if (rx_byte == slf_pkg::TFESC) begin
          byte_d = slf_pkg::FESC;
        end
      end else if (rx_byte == slf_pkg::FEND) begin
        if (write_position != '0) begin
          push              = 1'b1;
          push_req.op       = slf_pkg::OP_FRAME;
          push_req.length   = slf_pkg::len_t'(write_position);
          push_req.accepted = (32'(write_position) >= 32'(min_frame_len));
        end
        write_position_next = '0;
      end else if (rx_byte == slf_pkg::FESC) begin
        escape_pending_next = 1'b1;
      end else begin
        do_store = 1'b1;
      end

      // full store: byte is dropped, length saturates
      if (do_store && (32'(write_position) < 32'(FRAME_CAPACITY))) begin
        push                = 1'b1;
        push_req.op         = slf_pkg::OP_WRITE;
        push_req.addr       = slf_pkg::addr_t'(write_position);
        push_req.data       = byte_d;
        write_position_next = write_position + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      write_position <= '0;
      min_frame_len  <= slf_pkg::MIN_LEN_RESET;
    end else begin
      escape_pending <= escape_pending_next;
      write_position <= write_position_next;
      if (cfg_valid && cfg_ready) begin
        min_frame_len <= cfg_data;
      end
    end
  end

endmodule

// ===== hdl/slf_queue.sv =====
// Short in-order request queue between front and back ends.
// Uses slf_pkg for the request type and depth.
module slf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  slf_pkg::req_t push_req,
  output logic          full,
  input  logic          pop,
  output slf_pkg::req_t head,
  output logic          empty
);

  slf_pkg::req_t                  slots [slf_pkg::QUEUE_DEPTH];
  logic [slf_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [slf_pkg::QCNT_W-1:0]     count;

  assign full  = (count == slf_pkg::QCNT_W'(slf_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + slf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + slf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + slf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - slf_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("request popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= slf_pkg::QCNT_W'(slf_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + slf_pkg::QCNT_W'(1)))
    else $error("queue count did not follow push");

endmodule

// ===== hdl/slf_back.sv =====
// Back end: executes queued requests against the frame store and holds the
// result register that faces the output channel. Uses slf_pkg.
module slf_back #(
  parameter int FRAME_CAPACITY = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  slf_pkg::req_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          result_kind,
  output logic [11:0]   frame_length,
  output logic          frame_accepted,
  output logic [7:0]    read_data
);

  localparam int AW = $clog2(FRAME_CAPACITY);

  logic [7:0]     mem [FRAME_CAPACITY];
  logic [7:0]     mem_q;
  logic           res_valid;
  logic           res_kind;
  slf_pkg::len_t  res_len;
  logic           res_acc;
  logic           res_use_mem;
  logic           is_write;
  logic           room;
  logic           load_res;
  logic [AW-1:0]  addr;

  assign is_write = (head.op == slf_pkg::OP_WRITE);
  assign room     = !res_valid || !out_stall;
  // store writes need no result slot; at the head one never waits on the output
  assign pop      = !empty && (is_write || room);
  assign load_res = pop && !is_write;
  assign addr     = AW'(head.addr);

  always_ff @(posedge clk) begin
    if (pop && is_write) begin
      mem[addr] <= head.data;
    end
    if (pop && (head.op == slf_pkg::OP_READ)) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_kind    <= (head.op == slf_pkg::OP_READ) ? slf_pkg::KIND_READ
                                                    : slf_pkg::KIND_FRAME;
      res_len     <= head.length;
      res_acc     <= head.accepted;
      res_use_mem <= (head.op == slf_pkg::OP_READ) && head.in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  assign out_valid      = res_valid;
  assign result_kind    = res_kind;
  assign frame_length   = res_len;
  assign frame_accepted = res_acc;
  assign read_data      = res_use_mem ? mem_q : 8'd0;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_stall) |=> (res_valid && $stable(res_kind) && $stable(res_len)))
    else $error("pending result changed while stalled");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    load_res |-> room)
    else $error("result loaded over an unaccepted one");

  a_read_reply_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_kind == slf_pkg::KIND_READ) |-> (res_len == '0 && !res_acc))
    else $error("read reply carries frame fields");

endmodule

// ===== hdl/slip_frame_receiver_unit.sv =====
// Top level of the SLIP frame receiver.
// Instantiates slf_front, slf_queue and slf_back; uses slf_pkg.
//
// SLIP receive decoder: each receive item (command 0) is one raw serial byte;
// escapes are undone and decoded bytes are written to a frame store of
// FRAME_CAPACITY bytes. An END closing a non-empty frame yields one result
// with the saturated length and whether it meets min_frame_len; a read item
// (command 1) yields one result with the stored byte (0 past capacity).
// One item is taken every cycle while the four-entry request queue has room.
// A result is offered from the edge that pops its request; the request is
// first registered in the queue and waits behind every request ahead of it.
// A stalled output holds back reads and frame closes while store writes at
// the queue head keep draining. min_frame_len resets to 20; the user must
// write it through the cfg port only while idle (the block does not enforce
// this). Store entries never written read back undefined.
module slip_frame_receiver_unit #(
  parameter int FRAME_CAPACITY = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  input  logic [10:0] read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [11:0] frame_length,
  output logic        frame_accepted,
  output logic [7:0]  read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  logic          push;
  slf_pkg::req_t push_req;
  logic          full;
  logic          pop;
  slf_pkg::req_t head;
  logic          empty;

  slf_front #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .rx_byte   (rx_byte),
    .read_index(read_index),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_req  (push_req),
    .full      (full)
  );

  slf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_req(push_req),
    .full    (full),
    .pop     (pop),
    .head    (head),
    .empty   (empty)
  );

  slf_back #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .frame_length  (frame_length),
    .frame_accepted(frame_accepted),
    .read_data     (read_data)
  );

endmodule
